// ===== sv/bdpc_pkg.sv =====
// Shared types and constants for the button debounce and press classifier.
`default_nettype none
package bdpc_pkg;

  localparam int unsigned NUM_BUTTONS = 8;
  localparam int unsigned BTN_W       = $clog2(NUM_BUTTONS);
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0]  STABLE_MAX        = 8'd255;
  localparam logic [15:0] HOLD_MAX          = 16'hFFFF;
  localparam logic [7:0]  MIN_DEBOUNCE      = 8'd2;
  localparam logic [15:0] DEFAULT_LONG      = 16'd100;
  localparam logic [15:0] DEFAULT_VERY_LONG = 16'd300;
  localparam logic [16:0] VERY_LONG_GAP     = 17'd200;

  localparam logic [7:0]  RST_DEBOUNCE      = 8'd5;
  localparam logic [15:0] RST_LONG          = 16'd100;
  localparam logic [15:0] RST_VERY_LONG     = 16'd300;

  typedef enum logic [2:0] {
    EV_SHORT     = 3'd0,
    EV_LONG      = 3'd1,
    EV_VERY_LONG = 3'd2,
    EV_LATCH_ON  = 3'd3,
    EV_LATCH_OFF = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE_MASK     = 3'd0,
    CFG_ACTIVE_LOW_MASK = 3'd1,
    CFG_LATCHED_MASK    = 3'd2,
    CFG_SETTLE_COUNT    = 3'd3,
    CFG_LONG_TICKS      = 3'd4,
    CFG_VERY_LONG_TICKS = 3'd5,
    CFG_VERY_LONG_EN    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        raw_prev;
    logic [7:0]  stable_run;
    logic        debounced;
    logic [15:0] held_ticks;
    logic        long_done;
    logic        very_long_done;
  } btn_state_t;

  localparam btn_state_t STATE_RESET = '{
    raw_prev:       1'b0,
    stable_run:     STABLE_MAX,
    debounced:      1'b0,
    held_ticks:     16'd0,
    long_done:      1'b0,
    very_long_done: 1'b0
  };

endpackage
`default_nettype wire

// ===== sv/bdpc_in_if.sv =====
// Tick sample channel: button index and raw pin level.
`default_nettype none
interface bdpc_in_if;
  logic                           valid;
  logic                           ready;
  logic [bdpc_pkg::BTN_W-1:0]     button;
  logic                           level;

  modport source (output valid, output button, output level, input ready);
  modport sink   (input valid, input button, input level, output ready);
endinterface
`default_nettype wire

// ===== sv/bdpc_out_if.sv =====
// Press event channel: button index and event code.
`default_nettype none
interface bdpc_out_if;
  logic                           valid;
  logic                           ready;
  logic [bdpc_pkg::BTN_W-1:0]     button_out;
  logic [2:0]                     event_res;

  modport source (output valid, output button_out, output event_res, input ready);
  modport sink   (input valid, input button_out, input event_res, output ready);
endinterface
`default_nettype wire

// ===== sv/button_debounce_press_classifier.sv =====
// Top level of the button debounce and press classifier.
// Each transaction on in_ch is one poll tick of one button. The per-button state
// (last raw level, stable run, debounced level, hold count, fired flags) sits in a
// small synchronous memory: the entry is read as the tick is accepted and written
// back as the tick leaves the update stage, and a forwarding register covers the
// following tick of the same button. The block takes one tick per cycle, each tick
// presents its event, if any, on out_ch from the output register, loaded as the tick
// leaves the update stage, and it stalls only while an event waits in the output
// register. Write configuration through cfg_we only while no tick is in flight.
`default_nettype none
module button_debounce_press_classifier (
  input  wire logic                              clk,
  input  wire logic                              rst,
  bdpc_in_if.sink                                in_ch,
  bdpc_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [bdpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bdpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned NB = bdpc_pkg::NUM_BUTTONS;
  localparam int unsigned BW = bdpc_pkg::BTN_W;

  logic [NB-1:0] enable_mask;
  logic [NB-1:0] active_low_mask;
  logic [NB-1:0] latched_mask;
  logic [7:0]    settle_count;
  logic [15:0]   long_ticks;
  logic [15:0]   very_long_ticks;
  logic          very_long_enable;

  bdpc_pkg::btn_state_t mem [NB];
  logic [NB-1:0]        ent_valid;

  bdpc_pkg::btn_state_t rd_data;
  logic                 rd_valid;
  logic                 s1_valid;
  logic [BW-1:0]        s1_button;
  logic                 s1_level;

  logic                 fwd_valid;
  logic [BW-1:0]        fwd_addr;
  bdpc_pkg::btn_state_t fwd_data;

  logic                 out_valid;
  logic [BW-1:0]        out_button;
  bdpc_pkg::event_t     out_event;

  bdpc_pkg::btn_state_t st;
  bdpc_pkg::btn_state_t st_next;
  logic                 s1_wr;
  logic                 s1_emit;
  bdpc_pkg::event_t     s1_event;
  logic                 s1_go;
  logic                 in_accept;

  logic                 raw;
  logic                 latched;
  logic [7:0]           thr;
  logic [15:0]          lt;
  logic [16:0]          vlt;
  logic [16:0]          vlt_base;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask      <= '0;
      active_low_mask  <= '0;
      latched_mask     <= '0;
      settle_count     <= bdpc_pkg::RST_DEBOUNCE;
      long_ticks       <= bdpc_pkg::RST_LONG;
      very_long_ticks  <= bdpc_pkg::RST_VERY_LONG;
      very_long_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        bdpc_pkg::CFG_ENABLE_MASK:     enable_mask      <= cfg_data[NB-1:0];
        bdpc_pkg::CFG_ACTIVE_LOW_MASK: active_low_mask  <= cfg_data[NB-1:0];
        bdpc_pkg::CFG_LATCHED_MASK:    latched_mask     <= cfg_data[NB-1:0];
        bdpc_pkg::CFG_SETTLE_COUNT:    settle_count     <= cfg_data[7:0];
        bdpc_pkg::CFG_LONG_TICKS:      long_ticks       <= cfg_data[15:0];
        bdpc_pkg::CFG_VERY_LONG_TICKS: very_long_ticks  <= cfg_data[15:0];
        bdpc_pkg::CFG_VERY_LONG_EN:    very_long_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_accept   = in_ch.valid && in_ch.ready;
  assign s1_go       = s1_valid && (!s1_emit || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_go;

  // thresholds
  always_comb begin
    thr      = (settle_count < bdpc_pkg::MIN_DEBOUNCE) ? bdpc_pkg::MIN_DEBOUNCE
                                                       : settle_count;
    lt       = (long_ticks != 16'd0) ? long_ticks : bdpc_pkg::DEFAULT_LONG;
    vlt_base = {1'b0, (very_long_ticks != 16'd0) ? very_long_ticks
                                                 : bdpc_pkg::DEFAULT_VERY_LONG};
    vlt      = (vlt_base <= {1'b0, lt}) ? ({1'b0, lt} + bdpc_pkg::VERY_LONG_GAP)
                                        : vlt_base;
  end

  // update of one button entry
  always_comb begin
    if (fwd_valid && fwd_addr == s1_button) begin
      st = fwd_data;
    end else if (rd_valid) begin
      st = rd_data;
    end else begin
      st = bdpc_pkg::STATE_RESET;
    end
    st_next  = st;
    s1_wr    = 1'b0;
    s1_emit  = 1'b0;
    s1_event = bdpc_pkg::EV_SHORT;
    raw      = s1_level ^ active_low_mask[s1_button];
    latched  = latched_mask[s1_button];
    if (s1_valid && enable_mask[s1_button]) begin
      s1_wr = 1'b1;
      if (raw != st.raw_prev) begin
        st_next.stable_run = 8'd0;
        st_next.raw_prev   = raw;
      end else begin
        if (st.stable_run != bdpc_pkg::STABLE_MAX) begin
          st_next.stable_run = st.stable_run + 8'd1;
        end
        if (st_next.stable_run >= thr) begin
          if (raw != st.debounced) begin
            st_next.debounced = raw;
            if (latched) begin
              s1_emit  = 1'b1;
              s1_event = raw ? bdpc_pkg::EV_LATCH_ON : bdpc_pkg::EV_LATCH_OFF;
            end else if (raw) begin
              st_next.held_ticks     = 16'd0;
              st_next.long_done      = 1'b0;
              st_next.very_long_done = 1'b0;
            end else if (!st.long_done && !st.very_long_done) begin
              s1_emit  = 1'b1;
              s1_event = bdpc_pkg::EV_SHORT;
            end
          end else if (!latched && st.debounced) begin
            if (st.held_ticks != bdpc_pkg::HOLD_MAX) begin
              st_next.held_ticks = st.held_ticks + 16'd1;
            end
            if (!st.very_long_done && very_long_enable
                && {1'b0, st_next.held_ticks} >= vlt) begin
              st_next.very_long_done = 1'b1;
              s1_emit  = 1'b1;
              s1_event = bdpc_pkg::EV_VERY_LONG;
            end else if (!st.long_done && st_next.held_ticks >= lt) begin
              st_next.long_done = 1'b1;
              s1_emit  = 1'b1;
              s1_event = bdpc_pkg::EV_LONG;
            end
          end
        end
      end
    end
  end

  // state memory
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data <= mem[in_ch.button];
    end
    if (s1_go && s1_wr) begin
      mem[s1_button] <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_go && s1_wr) begin
        ent_valid[s1_button] <= 1'b1;
      end
      if (in_accept) begin
        rd_valid <= ent_valid[in_ch.button];
      end
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (!s1_valid || s1_go) begin
        fwd_valid <= s1_go && s1_wr;
      end
      if (s1_go && s1_emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_button <= in_ch.button;
      s1_level  <= in_ch.level;
    end
    if (s1_go && s1_wr) begin
      fwd_addr <= s1_button;
      fwd_data <= st_next;
    end
    if (s1_go && s1_emit) begin
      out_button <= s1_button;
      out_event  <= s1_event;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.button_out = out_button;
  assign out_ch.event_res  = out_event;

  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !in_ch.ready) |-> (out_valid && !out_ch.ready))
    else $error("tick stage stalled with a free output register");

  a_event_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_emit) |=> out_valid)
    else $error("event lost on its way to the output register");

  a_forward_entry_written: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> ent_valid[fwd_addr])
    else $error("forwarded entry not marked as written");

  a_held_entry_pending: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_button) && $stable(fwd_valid)))
    else $error("stalled tick lost its entry or forwarding state");

endmodule
`default_nettype wire
